// File: src/mld_pkg.sv
package mld_pkg;

   // fixed field widths
   localparam int TOKEN_W = 32;   // token port
   localparam int IDX_W   = 6;    // line index / count, 0..32
   localparam int STEP_W  = 7;    // edit distance / step count, 0..64
   localparam int PT_W    = 7;    // search coordinate, may run past the end by d
   localparam int SK_W    = 10;   // signed diagonal arithmetic

   localparam int MAX_LINES_DEF  = 32;
   localparam int TOKEN_BITS_DEF = 32;

   // command codes
   localparam logic [1:0] CMD_LOAD_OLD = 2'd0;
   localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
   localparam logic [1:0] CMD_RUN      = 2'd2;

   // script op codes
   localparam logic [1:0] OP_KEEP   = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;

   // one backtrack step written into the script store
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] px;
      logic [IDX_W-1:0] py;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] y;
   } mld_step_wr_type;

   // search done, script emission may start
   typedef struct packed {
      logic              valid;
      logic [STEP_W-1:0] steps;
      logic [IDX_W-1:0]  n;
      logic [IDX_W-1:0]  m;
   } mld_launch_type;

endpackage

// File: src/mld_core.sv
module mld_core #(
   parameter int MAX_LINES  = mld_pkg::MAX_LINES_DEF,
   parameter int TOKEN_BITS = mld_pkg::TOKEN_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_old,
   input  logic                         load_new,
   input  logic                         run,
   input  logic [mld_pkg::TOKEN_W-1:0]  token,
   output logic                         busy,
   output mld_pkg::mld_step_wr_type     step_wr,
   output mld_pkg::mld_launch_type      launch
);
   import mld_pkg::*;

   localparam int TW     = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;
   localparam int TA     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int DIAGS  = 4 * MAX_LINES + 1;
   localparam int OFF    = 2 * MAX_LINES;
   localparam int HDEPTH = (2 * MAX_LINES + 1) * DIAGS;
   localparam int HA     = $clog2(HDEPTH);
   localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_LINES);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_FK    = 8'b0000_0010,
      S_FWAIT = 8'b0000_0100,
      S_TRD   = 8'b0000_1000,
      S_SNK   = 8'b0001_0000,
      S_BCHK  = 8'b0010_0000,
      S_BRD2  = 8'b0100_0000,
      S_BEVAL = 8'b1000_0000
   } mld_core_state_type;

   // token stores
   logic [TW-1:0] old_mem [MAX_LINES];
   logic [TW-1:0] new_mem [MAX_LINES];
   logic [TW-1:0] old_q, new_q;
   logic [TA-1:0] old_raddr, new_raddr;

   // frontier history, one row of DIAGS entries per edit distance
   logic [PT_W-1:0] hist_mem [HDEPTH];
   logic [PT_W-1:0] hist_q;
   logic            hist_we, hist_re;
   logic [HA-1:0]   hist_waddr, hist_raddr;

   mld_core_state_type state_ff, state_in;
   logic [IDX_W-1:0]   old_cnt_ff, old_cnt_in, new_cnt_ff, new_cnt_in;
   logic [IDX_W-1:0]   n_ff, n_in, m_ff, m_in;
   logic [STEP_W-1:0]  d_ff, d_in, steps_ff, steps_in;
   logic signed [SK_W-1:0] k_ff, k_in;
   logic [PT_W-1:0]    x_ff, x_in, y_ff, y_in, lo_ff, lo_in;
   logic [HA-1:0]      row_ff, row_in, prow_ff, prow_in;

   logic signed [SK_W-1:0] d_s, ck, bt_lo, bt_hi, kp, diag_k, diag_k1, diag_lo, diag_hi;
   logic [PT_W-1:0]    x_sel, y_sel, n_ext, m_ext, px, py, dx, dy, t;
   logic [STEP_W-1:0]  nm_sum;
   logic               down_f, down_b, snake_go, found;

   assign d_s    = $signed({{(SK_W-STEP_W){1'b0}}, d_ff});
   assign ck     = $signed({{(SK_W-PT_W){1'b0}}, x_ff}) - $signed({{(SK_W-PT_W){1'b0}}, y_ff});
   assign bt_lo  = (ck == -d_s) ? ck + SK_W'(1) : ck - SK_W'(1);
   assign bt_hi  = (ck == d_s)  ? ck - SK_W'(1) : ck + SK_W'(1);
   assign diag_k  = k_ff + SK_W'(OFF);
   assign diag_k1 = k_ff + SK_W'(OFF + 1);
   assign diag_lo = bt_lo + SK_W'(OFF);
   assign diag_hi = bt_hi + SK_W'(OFF);
   assign n_ext  = PT_W'(n_ff);
   assign m_ext  = PT_W'(m_ff);
   assign nm_sum = STEP_W'(old_cnt_ff) + STEP_W'(new_cnt_ff);

   assign snake_go = (x_ff < n_ext) && (y_ff < m_ext) && (old_q == new_q);
   assign found    = (x_ff >= n_ext) && (y_ff >= m_ext);

   // backtrack choice: which predecessor diagonal the path came from
   assign down_b = (ck == -d_s) || ((ck != d_s) && (lo_ff < hist_q));
   assign kp     = down_b ? ck + SK_W'(1) : ck - SK_W'(1);
   assign px     = down_b ? hist_q : lo_ff;
   assign py     = PT_W'($unsigned($signed({{(SK_W-PT_W){1'b0}}, px}) - kp));
   assign dx     = x_ff - px;
   assign dy     = y_ff - py;
   assign t      = (dx < dy) ? dx : dy;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      old_cnt_in = old_cnt_ff;
      new_cnt_in = new_cnt_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      d_in       = d_ff;
      steps_in   = steps_ff;
      k_in       = k_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      lo_in      = lo_ff;
      row_in     = row_ff;
      prow_in    = prow_ff;
      hist_we    = 1'b0;
      hist_re    = 1'b0;
      hist_waddr = row_ff + HA'($unsigned(diag_k));
      hist_raddr = prow_ff + HA'($unsigned(diag_k1));
      old_raddr  = x_ff[TA-1:0];
      new_raddr  = y_ff[TA-1:0];
      down_f     = 1'b0;
      x_sel      = x_ff;
      step_wr    = '0;
      launch     = '0;

      if (load_old && (old_cnt_ff < MAX_CNT)) begin
         old_cnt_in = old_cnt_ff + IDX_W'(1);
      end
      if (load_new && (new_cnt_ff < MAX_CNT)) begin
         new_cnt_in = new_cnt_ff + IDX_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (run) begin
               n_in       = old_cnt_ff;
               m_in       = new_cnt_ff;
               old_cnt_in = '0;
               new_cnt_in = '0;
               d_in       = '0;
               k_in       = '0;
               row_in     = '0;
               prow_in    = '0;
               if (nm_sum != '0) begin
                  state_in = S_FK;
               end
            end
         end
         S_FK: begin
            if (d_ff == '0) begin
               x_sel    = '0;
               state_in = S_TRD;
            end else if (k_ff == d_s) begin
               x_sel    = lo_ff + PT_W'(1);
               state_in = S_TRD;
            end else begin
               hist_re  = 1'b1;
               state_in = S_FWAIT;
            end
            x_in = x_sel;
         end
         S_FWAIT: begin
            down_f   = (k_ff == -d_s) || (lo_ff < hist_q);
            x_sel    = down_f ? hist_q : lo_ff + PT_W'(1);
            x_in     = x_sel;
            lo_in    = hist_q;
            state_in = S_TRD;
         end
         S_TRD: begin
            state_in = S_SNK;
         end
         S_SNK: begin
            old_raddr = TA'(x_ff + PT_W'(1));
            new_raddr = TA'(y_ff + PT_W'(1));
            if (snake_go) begin
               x_in = x_ff + PT_W'(1);
               y_in = y_ff + PT_W'(1);
            end else begin
               hist_we = 1'b1;
               if (found) begin
                  x_in     = n_ext;
                  y_in     = m_ext;
                  steps_in = '0;
                  state_in = S_BCHK;
               end else if (k_ff == d_s) begin
                  d_in    = d_ff + STEP_W'(1);
                  k_in    = -d_s - SK_W'(1);
                  prow_in = row_ff;
                  row_in  = row_ff + HA'(DIAGS);
                  if (d_ff + STEP_W'(1) > STEP_W'(n_ff) + STEP_W'(m_ff)) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_FK;
                  end
               end else begin
                  k_in     = k_ff + SK_W'(2);
                  state_in = S_FK;
               end
            end
         end
         S_BCHK: begin
            if (d_ff == '0) begin
               launch.valid = 1'b1;
               launch.steps = steps_ff;
               launch.n     = n_ff;
               launch.m     = m_ff;
               state_in     = S_IDLE;
            end else begin
               hist_re    = 1'b1;
               hist_raddr = prow_ff + HA'($unsigned(diag_lo));
               state_in   = S_BRD2;
            end
         end
         S_BRD2: begin
            lo_in      = hist_q;
            hist_re    = 1'b1;
            hist_raddr = prow_ff + HA'($unsigned(diag_hi));
            state_in   = S_BEVAL;
         end
         S_BEVAL: begin
            step_wr.valid = 1'b1;
            step_wr.addr  = IDX_W'(steps_ff);
            step_wr.px    = IDX_W'(px);
            step_wr.py    = IDX_W'(py);
            step_wr.x     = IDX_W'(x_ff - t);
            step_wr.y     = IDX_W'(y_ff - t);
            steps_in      = steps_ff + STEP_W'(1);
            x_in          = px;
            y_in          = py;
            d_in          = d_ff - STEP_W'(1);
            row_in        = prow_ff;
            prow_in       = prow_ff - HA'(DIAGS);
            state_in      = S_BCHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      y_sel = PT_W'($unsigned($signed({{(SK_W-PT_W){1'b0}}, x_sel}) - k_ff));
      if ((state_ff == S_FK) || (state_ff == S_FWAIT)) begin
         y_in = y_sel;
      end
      if (state_ff == S_TRD || state_ff == S_FK || state_ff == S_FWAIT) begin
         old_raddr = x_ff[TA-1:0];
         new_raddr = y_ff[TA-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         old_cnt_ff <= '0;
         new_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         old_cnt_ff <= old_cnt_in;
         new_cnt_ff <= new_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      m_ff     <= m_in;
      d_ff     <= d_in;
      steps_ff <= steps_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      lo_ff    <= lo_in;
      row_ff   <= row_in;
      prow_ff  <= prow_in;
   end

   always_ff @(posedge clock) begin
      if (load_old && (old_cnt_ff < MAX_CNT)) begin
         old_mem[old_cnt_ff[TA-1:0]] <= token[TW-1:0];
      end
      if (load_new && (new_cnt_ff < MAX_CNT)) begin
         new_mem[new_cnt_ff[TA-1:0]] <= token[TW-1:0];
      end
      old_q <= old_mem[old_raddr];
      new_q <= new_mem[new_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= x_ff;
      end
      if (hist_re) begin
         hist_q <= hist_mem[hist_raddr];
      end
   end

endmodule

// File: src/mld_emit.sv
module mld_emit #(
   parameter int MAX_LINES = mld_pkg::MAX_LINES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mld_pkg::mld_step_wr_type       step_wr,
   input  mld_pkg::mld_launch_type        launch,
   output logic                           busy,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_op,
   output logic [mld_pkg::IDX_W-1:0]      rsp_old_index,
   output logic [mld_pkg::IDX_W-1:0]      rsp_new_index,
   output logic                           rsp_last
);
   import mld_pkg::*;

   localparam int SD = 2 * MAX_LINES;
   localparam int SA = $clog2(SD);
   localparam int EW = 4 * IDX_W;

   typedef enum logic [4:0] {
      E_IDLE = 5'b00001,
      E_RD   = 5'b00010,
      E_KEEP = 5'b00100,
      E_TAIL = 5'b01000,
      E_FIN  = 5'b10000
   } mld_emit_state_type;

   logic [EW-1:0] step_mem [SD];
   logic [EW-1:0] mem_q;
   logic          rd_en;

   mld_emit_state_type state_ff, state_in;
   logic [STEP_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]   n_ff, n_in, m_ff, m_in, cx_ff, cx_in, cy_ff, cy_in;
   logic               pend_v_ff, pend_v_in;
   logic [1:0]         pend_op_ff, pend_op_in;
   logic [IDX_W-1:0]   pend_oi_ff, pend_oi_in, pend_ni_ff, pend_ni_in;
   logic               out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic [1:0]         out_op_ff, out_op_in;
   logic [IDX_W-1:0]   out_oi_ff, out_oi_in, out_ni_ff, out_ni_in;

   logic               gen_v;
   logic [1:0]         gen_op;
   logic [IDX_W-1:0]   gen_oi, gen_ni;
   logic [IDX_W-1:0]   e_px, e_py, e_x, e_y;

   assign e_px = mem_q[EW-1 -: IDX_W];
   assign e_py = mem_q[EW-IDX_W-1 -: IDX_W];
   assign e_x  = mem_q[2*IDX_W-1 -: IDX_W];
   assign e_y  = mem_q[IDX_W-1:0];

   assign busy          = (state_ff != E_IDLE);
   assign rsp_strobe    = out_v_ff;
   assign rsp_op        = out_op_ff;
   assign rsp_old_index = out_oi_ff;
   assign rsp_new_index = out_ni_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rd_en      = 1'b0;
      gen_v      = 1'b0;
      gen_op     = OP_KEEP;
      gen_oi     = cx_ff;
      gen_ni     = cy_ff;
      pend_v_in  = pend_v_ff;
      pend_op_in = pend_op_ff;
      pend_oi_in = pend_oi_ff;
      pend_ni_in = pend_ni_ff;
      out_v_in   = 1'b0;
      out_last_in = 1'b0;
      out_op_in  = out_op_ff;
      out_oi_in  = out_oi_ff;
      out_ni_in  = out_ni_ff;

      case (state_ff)
         E_IDLE: begin
            if (launch.valid) begin
               i_in  = launch.steps;
               n_in  = launch.n;
               m_in  = launch.m;
               cx_in = '0;
               cy_in = '0;
               state_in = (launch.steps == '0) ? E_TAIL : E_RD;
            end
         end
         E_RD: begin
            rd_en    = 1'b1;
            state_in = E_KEEP;
         end
         E_KEEP: begin
            if ((cx_ff < e_px) && (cy_ff < e_py)) begin
               gen_v = 1'b1;
               cx_in = cx_ff + IDX_W'(1);
               cy_in = cy_ff + IDX_W'(1);
            end else begin
               if (e_x > e_px) begin
                  gen_v  = 1'b1;
                  gen_op = OP_DELETE;
                  gen_oi = e_px;
                  cx_in  = cx_ff + IDX_W'(1);
               end else if (e_y > e_py) begin
                  gen_v  = 1'b1;
                  gen_op = OP_INSERT;
                  gen_ni = e_py;
                  cy_in  = cy_ff + IDX_W'(1);
               end
               i_in     = i_ff - STEP_W'(1);
               state_in = (i_ff == STEP_W'(1)) ? E_TAIL : E_RD;
            end
         end
         E_TAIL: begin
            if ((cx_ff < n_ff) && (cy_ff < m_ff)) begin
               gen_v = 1'b1;
               cx_in = cx_ff + IDX_W'(1);
               cy_in = cy_ff + IDX_W'(1);
            end else begin
               state_in = E_FIN;
            end
         end
         E_FIN: begin
            // flush the held item as the final one
            out_v_in    = pend_v_ff;
            out_last_in = pend_v_ff;
            out_op_in   = pend_op_ff;
            out_oi_in   = pend_oi_ff;
            out_ni_in   = pend_ni_ff;
            pend_v_in   = 1'b0;
            state_in    = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase

      // one item is held back so the last one can be marked
      if (gen_v) begin
         out_v_in   = pend_v_ff;
         out_op_in  = pend_op_ff;
         out_oi_in  = pend_oi_ff;
         out_ni_in  = pend_ni_ff;
         pend_v_in  = 1'b1;
         pend_op_in = gen_op;
         pend_oi_in = gen_oi;
         pend_ni_in = gen_ni;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= E_IDLE;
         pend_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_v_ff   <= pend_v_in;
         out_v_ff    <= out_v_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      n_ff       <= n_in;
      m_ff       <= m_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      pend_op_ff <= pend_op_in;
      pend_oi_ff <= pend_oi_in;
      pend_ni_ff <= pend_ni_in;
      out_op_ff  <= out_op_in;
      out_oi_ff  <= out_oi_in;
      out_ni_ff  <= out_ni_in;
   end

   always_ff @(posedge clock) begin
      if (step_wr.valid) begin
         step_mem[step_wr.addr[SA-1:0]] <= {step_wr.px, step_wr.py, step_wr.x, step_wr.y};
      end
      if (rd_en) begin
         mem_q <= step_mem[SA'(i_ff - STEP_W'(1))];
      end
   end

endmodule

// File: src/myers_line_diff.sv
// Line diff engine: shortest edit script between two token sequences.
//
// Command channel: start/busy with req_cmd, req_token. A command transfers on
// a rising edge with start high and busy low. Load commands append a token to
// the old or new sequence (MAX_LINES each; loads beyond that are dropped);
// loads stream one per cycle while busy is low. cmd 3 is ignored.
// A run command searches forward one edit distance d at a time, keeping each
// frontier row in the history RAM, then backtracks from the end point and
// emits the script. Per diagonal the search passes through S_FK, S_FWAIT
// (skipped when d is 0 or k equals d), S_TRD and S_SNK, which follows the
// snake line by line (token RAMs read one pair per cycle); backtrack passes
// through S_BCHK, S_BRD2 and S_BEVAL per edit; emission reads each stored
// edit, expands the keeps before it and ends with a final flush.
// Busy stays high for the whole run. Both counts are zero after a run.
// Result channel: rsp_strobe marks one item per cycle-long transfer with
// rsp_op, rsp_old_index, rsp_new_index; rsp_last flags the final item. The
// receiver cannot stall; items come out whenever they are ready.
// A run with both sequences empty produces nothing.
// Reset (synchronous) clears the counts and all control; RAM contents are
// not cleared, and only entries that have been written are ever used.
module myers_line_diff #(
   parameter int MAX_LINES  = mld_pkg::MAX_LINES_DEF,
   parameter int TOKEN_BITS = mld_pkg::TOKEN_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_cmd,
   input  logic [mld_pkg::TOKEN_W-1:0] req_token,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_op,
   output logic [mld_pkg::IDX_W-1:0]   rsp_old_index,
   output logic [mld_pkg::IDX_W-1:0]   rsp_new_index,
   output logic                        rsp_last
);
   import mld_pkg::*;

   logic           accept;
   logic           core_busy, emit_busy;
   mld_step_wr_type step_wr;
   mld_launch_type  launch;

   // a command transfers only when neither search nor emission is active
   assign accept = start && !busy;
   assign busy   = core_busy || emit_busy;

   mld_core #(
      .MAX_LINES  (MAX_LINES),
      .TOKEN_BITS (TOKEN_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .load_old (accept && (req_cmd == CMD_LOAD_OLD)),
      .load_new (accept && (req_cmd == CMD_LOAD_NEW)),
      .run      (accept && (req_cmd == CMD_RUN)),
      .token    (req_token),
      .busy     (core_busy),
      .step_wr  (step_wr),
      .launch   (launch)
   );

   // walks the stored edit steps newest-first and expands them into items
   mld_emit #(
      .MAX_LINES (MAX_LINES)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .step_wr       (step_wr),
      .launch        (launch),
      .busy          (emit_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_op        (rsp_op),
      .rsp_old_index (rsp_old_index),
      .rsp_new_index (rsp_new_index),
      .rsp_last      (rsp_last)
   );

   // no results while the search is still running
   a_no_rsp_in_search: assert property (@(posedge clock) disable iff (reset)
      core_busy |-> !rsp_strobe)
      else $error("result during search");

   // op code on a result is always a defined one
   a_op_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_op == OP_KEEP) || (rsp_op == OP_DELETE) ||
                      (rsp_op == OP_INSERT)))
      else $error("undefined op");

   // nothing follows the last item right away
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("item after last");

   // a launch only happens while emission is idle
   a_launch_idle: assert property (@(posedge clock) disable iff (reset)
      launch.valid |-> !emit_busy)
      else $error("launch while emitting");

endmodule
